// File: design/ih_pkg.sv
// ----------------------------------------------------------------------------
// ih_pkg: shared types and constants of the intensity histogram
// Item layouts, register codes, chain link and cell control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ih_pkg;

  // store geometry
  localparam int MAX_BINS    = 64;
  localparam int COUNT_WIDTH = 24;

  // field widths fixed by the item layouts
  localparam int INT_W   = 8;   // pixel intensity
  localparam int SEL_W   = 6;   // bin select field
  localparam int NBR_W   = 7;   // num_bins register
  localparam int MAXV_W  = 8;   // max_value register
  localparam int RECIP_W = 25;  // reciprocal, Q0.24
  localparam int BCNT_W  = 24;  // bin_count field
  localparam int FRAC_W  = 17;  // bin_fraction field, Q0.16 up to 1.0

  // derived widths
  localparam int IDX_BITS = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int BIN_W    = (IDX_BITS > SEL_W) ? IDX_BITS : SEL_W;
  localparam int NB_W     = $clog2(MAX_BINS + 1) + 1;   // effective bin count
  localparam int WID_W    = MAXV_W + 1;                 // bucket width, up to 256
  localparam int OCC_W    = $clog2(MAX_BINS + 1);
  localparam int PROD_W   = COUNT_WIDTH + RECIP_W;

  // register file
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_NUM_BINS  = 2'd0;
  localparam logic [1:0] REG_MAX_VALUE = 2'd1;
  localparam logic [1:0] REG_RECIP     = 2'd2;

  // register reset values
  localparam logic [NBR_W-1:0]   RST_NUM_BINS  = NBR_W'(64);
  localparam logic [MAXV_W-1:0]  RST_MAX_VALUE = MAXV_W'(255);
  localparam logic [RECIP_W-1:0] RST_RECIP     = '0;

  // bucket width and last bin that follow from the reset registers
  localparam int RST_NEFF = (64 > MAX_BINS) ? MAX_BINS : 64;
  localparam logic [WID_W-1:0] RST_WIDTH    = WID_W'(255 / RST_NEFF + 1);
  localparam logic [BIN_W-1:0] RST_LAST_BIN = BIN_W'(RST_NEFF - 1);

  // request codes
  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // counter and fraction limits
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [FRAC_W-1:0] FRACTION_ONE = FRAC_W'(65536);

  typedef struct packed {
    logic              req_type;
    logic [INT_W-1:0]  intensity;
    logic [SEL_W-1:0]  bin_select;
  } in_item_t;

  typedef struct packed {
    logic [BCNT_W-1:0] bin_count;
    logic [FRAC_W-1:0] bin_fraction;
  } out_item_t;

  // item as it travels down the row of cells
  typedef struct packed {
    logic                   vld;
    logic                   req;
    logic                   placed;  // pixel already counted
    logic [INT_W-1:0]       resid;   // intensity minus widths passed so far
    logic [BIN_W-1:0]       sel;
    logic [COUNT_WIDTH-1:0] count;   // count picked up by a read
  } link_t;

  // control shared by every cell
  typedef struct packed {
    logic             adv;
    logic [WID_W-1:0] width;
    logic [BIN_W-1:0] last;
  } cell_ctl_t;

endpackage

// File: design/intensity_histogram_unit.sv
// ----------------------------------------------------------------------------
// intensity_histogram_unit: pixel intensity histogram with read and clear
// Row of bin cells fed by a valid/stall stream, APB-style register port.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : items of one of two kinds. An accumulate item bins its intensity
//           into bin intensity / (max_value / num_bins + 1), clamped to the
//           last bin in use; its counter saturates. A read item returns one
//           bin's count and Q0.16 fraction on out_* and clears the bin.
//   out_* : one item per read, none per accumulate, in input order.
//   APB   : num_bins at 0x0, max_value at 0x4, recip_pixel_count at 0x8.
// Timing
//   Items walk down a row of MAX_BINS cells, one cell per cycle while the
//   row is not held, then a multiply stage and the output register. One
//   item is accepted per cycle unless in_stall is raised, set by the
//   one-cell-per-cycle row.
//   A write to num_bins or max_value starts a width division; the input
//   stalls until it ends and the row has drained.
// Reset and stall
//   Reset clears every bin counter at once and loads the register defaults.
//   While a result waits under out_stall the whole row holds and in_stall
//   is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module intensity_histogram_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ih_pkg::in_item_t           in_data,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output ih_pkg::out_item_t          out_data,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ih_pkg::ADDR_W-1:0]  paddr,
  input  logic [ih_pkg::DATA_W-1:0]  pwdata,
  output logic [ih_pkg::DATA_W-1:0]  prdata,
  output logic                       pready
);
  import ih_pkg::*;

  logic [NBR_W-1:0]   num_bins_r;
  logic [MAXV_W-1:0]  max_value_r;
  logic [RECIP_W-1:0] recip_r;
  logic [1:0]         reg_idx;
  logic               wr_en, wr_shape;
  logic               start_r, pend_r, pend_nxt, apply;
  logic               div_busy, div_done;
  logic [WID_W-1:0]   div_width;
  logic [NB_W-1:0]    n_eff;
  logic [WID_W-1:0]   act_width_r;
  logic [BIN_W-1:0]   act_last_r;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic               hold, adv, accept;
  cell_ctl_t          ctl;
  link_t              chain [MAX_BINS+1];
  logic [MAX_BINS-1:0] chain_vld;

  // register port decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign wr_shape = wr_en && ((reg_idx == REG_NUM_BINS) || (reg_idx == REG_MAX_VALUE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r  <= RST_NUM_BINS;
      max_value_r <= RST_MAX_VALUE;
      recip_r     <= RST_RECIP;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NUM_BINS:  num_bins_r  <= pwdata[NBR_W-1:0];
        REG_MAX_VALUE: max_value_r <= pwdata[MAXV_W-1:0];
        REG_RECIP:     recip_r     <= pwdata[RECIP_W-1:0];
        default:       ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_NUM_BINS:  prdata = DATA_W'(num_bins_r);
      REG_MAX_VALUE: prdata = DATA_W'(max_value_r);
      REG_RECIP:     prdata = DATA_W'(recip_r);
      default:       prdata = '0;
    endcase
  end

  // bins in use, clamped to one .. MAX_BINS
  always_comb begin
    n_eff = NB_W'(num_bins_r);
    if (n_eff == '0) begin
      n_eff = NB_W'(1);
    end else if (n_eff > NB_W'(MAX_BINS)) begin
      n_eff = NB_W'(MAX_BINS);
    end
  end

  // bucket width recompute after a shape register write
  ih_wdiv u_wdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (max_value_r),
    .divisor  (n_eff),
    .busy     (div_busy),
    .done     (div_done),
    .width    (div_width)
  );

  // new width goes live once the row holds no item
  assign apply = pend_r && (occ_r == '0);

  always_comb begin
    pend_nxt = pend_r;
    if (start_r) begin
      pend_nxt = 1'b0;
    end else if (div_done) begin
      pend_nxt = 1'b1;
    end else if (apply) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 1'b0;
      pend_r      <= 1'b0;
      act_width_r <= RST_WIDTH;
      act_last_r  <= RST_LAST_BIN;
    end else begin
      start_r <= wr_shape;
      pend_r  <= pend_nxt;
      if (apply) begin
        act_width_r <= div_width;
        act_last_r  <= BIN_W'(n_eff - 1'b1);
      end
    end
  end

  // flow control
  assign hold     = start_r || div_busy || div_done || pend_r;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = hold || !adv;
  assign accept   = in_valid && !in_stall;

  // items in the row
  always_comb begin
    occ_nxt = occ_r;
    if (accept && !(adv && chain[MAX_BINS].vld)) begin
      occ_nxt = occ_r + 1'b1;
    end else if (!accept && adv && chain[MAX_BINS].vld) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // head of the row
  assign chain[0].vld    = in_valid && !hold;
  assign chain[0].req    = in_data.req_type;
  assign chain[0].placed = 1'b0;
  assign chain[0].resid  = in_data.intensity;
  assign chain[0].sel    = BIN_W'(in_data.bin_select);
  assign chain[0].count  = '0;

  assign ctl.adv   = adv;
  assign ctl.width = act_width_r;
  assign ctl.last  = act_last_r;

  // row of bin cells
  for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
    ih_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .idx    (BIN_W'(k)),
      .link_i (chain[k]),
      .link_o (chain[k+1])
    );
    assign chain_vld[k] = chain[k+1].vld;
  end

  // fraction and output register
  ih_frac u_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .link_i    (chain[MAX_BINS]),
    .recip     (recip_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // the item count never exceeds the number of cells
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(MAX_BINS))
    else $error("row item count above cell count");

  // a zero item count means no valid flag is set in the row
  a_occ_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> (chain_vld == '0))
    else $error("row holds an item while count is zero");

  // a new width only goes live with the row empty
  a_apply_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (act_width_r != $past(act_width_r)) |-> ($past(occ_r) == '0))
    else $error("bucket width changed with items in flight");

  // bucket width is never zero
  a_width_nz: assert property (@(posedge clk) disable iff (!rst_n)
    act_width_r != '0)
    else $error("zero bucket width");

  // fraction never exceeds one
  a_frac_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.bin_fraction <= FRACTION_ONE))
    else $error("fraction above one");
`endif

endmodule

// File: design/ih_cell.sv
// ----------------------------------------------------------------------------
// ih_cell: one bin of the histogram row
// Holds one saturating counter; bins a passing pixel or serves a read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ih_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ih_pkg::cell_ctl_t         ctl,
  input  logic [ih_pkg::BIN_W-1:0]  idx,
  input  ih_pkg::link_t             link_i,
  output ih_pkg::link_t             link_o
);
  import ih_pkg::*;

  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  link_t                  link_r, link_nxt;
  logic                   is_acc, hit_acc, hit_rd;

  // pixel lands here when its residue is below one width, or at the last bin
  assign is_acc  = link_i.vld && (link_i.req == REQ_ACCUM) && !link_i.placed;
  assign hit_acc = is_acc &&
                   (({1'b0, link_i.resid} < ctl.width) || (idx == ctl.last));
  assign hit_rd  = link_i.vld && (link_i.req == REQ_READ) && (link_i.sel == idx);

  // counter update
  always_comb begin
    cnt_nxt = cnt_r;
    if (hit_rd) begin
      cnt_nxt = '0;
    end else if (hit_acc && (cnt_r != COUNT_MAX)) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // item handed to the next cell
  always_comb begin
    link_nxt = link_i;
    if (hit_acc) begin
      link_nxt.placed = 1'b1;
    end else if (is_acc) begin
      link_nxt.resid = link_i.resid - ctl.width[INT_W-1:0];
    end
    if (hit_rd) begin
      link_nxt.count = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      link_r.vld <= 1'b0;
    end else if (ctl.adv) begin
      cnt_r  <= cnt_nxt;
      link_r <= link_nxt;
    end
  end

  assign link_o = link_r;

endmodule

// File: design/ih_wdiv.sv
// ----------------------------------------------------------------------------
// ih_wdiv: bucket width divider
// Restoring division, one quotient bit per cycle: width = max_value / n + 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ih_wdiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ih_pkg::MAXV_W-1:0]  dividend,
  input  logic [ih_pkg::NB_W-1:0]    divisor,
  output logic                       busy,
  output logic                       done,
  output logic [ih_pkg::WID_W-1:0]   width
);
  import ih_pkg::*;

  localparam int STEP_W = $clog2(MAXV_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [NB_W-1:0]     rem_r, rem_nxt;
  logic [MAXV_W-1:0]   q_r, q_nxt;
  logic [NB_W-1:0]     dvs_r, dvs_nxt;
  logic [WID_W-1:0]    width_r, width_nxt;
  logic [NB_W:0]       trial;
  logic                take;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r, q_r[MAXV_W-1]};
  assign take  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    dvs_nxt   = dvs_r;
    width_nxt = width_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = take ? NB_W'(trial - {1'b0, dvs_r}) : trial[NB_W-1:0];
      q_nxt    = {q_r[MAXV_W-2:0], take};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(MAXV_W - 1)) begin
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        width_nxt = {1'b0, q_r[MAXV_W-2:0], take} + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      width_r <= RST_WIDTH;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      width_r <= width_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign width = width_r;

endmodule

// File: design/ih_frac.sv
// ----------------------------------------------------------------------------
// ih_frac: fraction stage and output register
// Multiplies a read count by the reciprocal, truncates to Q0.16, saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ih_frac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  ih_pkg::link_t               link_i,
  input  logic [ih_pkg::RECIP_W-1:0]  recip,
  output logic                        out_valid,
  output ih_pkg::out_item_t           out_data
);
  import ih_pkg::*;

  localparam logic [PROD_W-1:0] SAT_LIM = PROD_W'(65537) << 8;

  logic               m_vld_r;
  logic [BCNT_W-1:0]  m_count_r;
  logic [PROD_W-1:0]  m_prod_r;
  logic               o_vld_r;
  out_item_t          o_data_r, o_data_nxt;

  // multiply stage: only reads make a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= link_i.vld && (link_i.req == REQ_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_count_r <= BCNT_W'(link_i.count);
      m_prod_r  <= PROD_W'(link_i.count) * PROD_W'(recip);
    end
  end

  // truncate to Q0.16 and clamp at one
  always_comb begin
    o_data_nxt.bin_count = m_count_r;
    if (m_prod_r >= SAT_LIM) begin
      o_data_nxt.bin_fraction = FRACTION_ONE;
    end else begin
      o_data_nxt.bin_fraction = m_prod_r[FRAC_W+7:8];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_data_r <= o_data_nxt;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

endmodule

// File: dv/intensity_histogram_checker.sv
// ----------------------------------------------------------------------------
// intensity_histogram_checker: bin store predictor and result checker
// Watches the register port and both item channels, keeps a shadow of the
// bin counters and the registers, and compares every result item against
// the oldest predicted bin read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module intensity_histogram_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  ih_pkg::in_item_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  ih_pkg::out_item_t         out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ih_pkg::ADDR_W-1:0] paddr,
  input  logic [ih_pkg::DATA_W-1:0] pwdata,
  input  logic                      pready,
  output int                        mismatches,
  output int                        reads_due
);
  import ih_pkg::*;

  // shadow of the bin store and the registers
  logic [COUNT_WIDTH-1:0] count_shadow [MAX_BINS];
  logic [NBR_W-1:0]       nbins_q;
  logic [MAXV_W-1:0]      maxv_q;
  logic [RECIP_W-1:0]     recip_q;

  // bin reads still waiting for their result item
  out_item_t read_results_due [$];
  int        err_n = 0;

  // bins in use, with zero and oversized settings clamped
  function automatic int bins_used(input logic [NBR_W-1:0] nb);
    int n;
    n = int'(nb);
    if (n == 0) n = 1;
    if (n > MAX_BINS) n = MAX_BINS;
    return n;
  endfunction

  // bin a pixel lands in; bins past the last in use are clamped to the last bin
  function automatic int bucket_of(input logic [INT_W-1:0] pixel,
                                   input logic [NBR_W-1:0] nb,
                                   input logic [MAXV_W-1:0] mv);
    int n;
    int m;
    int p;
    int width;
    int bin;
    n = bins_used(nb);
    m = int'(mv);
    p = int'(pixel);
    width = m / n + 1;
    bin = p / width;
    if (bin >= n) bin = n - 1;
    return bin;
  endfunction

  // count times Q0.24 reciprocal, truncated to Q0.16, capped at one
  function automatic logic [FRAC_W-1:0] fraction_of(input logic [COUNT_WIDTH-1:0] count,
                                                    input logic [RECIP_W-1:0] recip);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(count);
    prod = prod * PROD_W'(recip);
    prod = prod >> 8;
    if (prod > PROD_W'(FRACTION_ONE)) return FRACTION_ONE;
    return prod[FRAC_W-1:0];
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        b;
    if (!rst_n) begin
      for (int i = 0; i < MAX_BINS; i++) count_shadow[i] = '0;
      nbins_q = RST_NUM_BINS;
      maxv_q  = RST_MAX_VALUE;
      recip_q = RST_RECIP;
      read_results_due.delete();
    end else begin
      // result side: compare with the oldest predicted read
      if (out_valid && !out_stall) begin
        if (read_results_due.size() == 0) begin
          if (err_n < 10)
            $display("unexpected result item: count %0d fraction %0d",
                     out_data.bin_count, out_data.bin_fraction);
          err_n++;
        end else begin
          want = read_results_due.pop_front();
          if (out_data.bin_count !== want.bin_count ||
              out_data.bin_fraction !== want.bin_fraction) begin
            if (err_n < 10)
              $display({"bin read mismatch: expected count %0d fraction %0d, ",
                        "got count %0d fraction %0d"},
                       want.bin_count, want.bin_fraction,
                       out_data.bin_count, out_data.bin_fraction);
            err_n++;
          end
        end
      end

      // input side: count a pixel or predict a read and clear
      if (in_valid && !in_stall) begin
        if (in_data.req_type == REQ_READ) begin
          b = int'(in_data.bin_select);
          want.bin_count    = BCNT_W'(count_shadow[b]);
          want.bin_fraction = fraction_of(count_shadow[b], recip_q);
          count_shadow[b]   = '0;
          read_results_due.push_back(want);
        end else begin
          b = bucket_of(in_data.intensity, nbins_q, maxv_q);
          if (count_shadow[b] != COUNT_MAX) count_shadow[b] = count_shadow[b] + 1'b1;
        end
      end

      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_NUM_BINS:  nbins_q = pwdata[NBR_W-1:0];
          REG_MAX_VALUE: maxv_q  = pwdata[MAXV_W-1:0];
          REG_RECIP:     recip_q = pwdata[RECIP_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches <= err_n;
    reads_due  <= read_results_due.size();
  end

endmodule

// File: dv/intensity_histogram_unit_test.sv
// ----------------------------------------------------------------------------
// intensity_histogram_unit_test: stimulus and verdict for the histogram unit
// Directed pixel and read items, then random phases over several register
// settings and idle patterns; a checker beside the block predicts results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module intensity_histogram_unit_test;
  import ih_pkg::*;

  localparam int DRAIN_CYCLES = MAX_BINS + 16;
  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_ITEMS  = 100;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int reads_due;

  // idle percentages of the current phase
  int send_idle  = 0;
  int recv_stall = 0;

  // register values as the stimulus sees them
  int stim_bins = 64;
  int stim_maxv = 255;

  intensity_histogram_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  intensity_histogram_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .reads_due  (reads_due)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall);
  end

  // run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("intensity_histogram_unit_test: FAIL");
    $finish;
  end

  // register write: setup cycle then access cycle
  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write all three registers and track what the stimulus needs
  task automatic apply_setting(input int nb, input int mv, input logic [DATA_W-1:0] recip);
    cfg_write(REG_NUM_BINS, DATA_W'(nb));
    cfg_write(REG_MAX_VALUE, DATA_W'(mv));
    cfg_write(REG_RECIP, recip);
    stim_bins = (nb == 0) ? 1 : ((nb > MAX_BINS) ? MAX_BINS : nb);
    stim_maxv = mv;
  endtask

  // present one item after a random gap, hold it until accepted
  task automatic send_item(input logic req, input int pixel, input int sel);
    in_item_t item;
    item.req_type   = req;
    item.intensity  = INT_W'(pixel);
    item.bin_select = SEL_W'(sel);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every read has come back and the row is empty
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (reads_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random items: mostly pixels, reads mostly of bins in use, an occasional sweep
  task automatic run_random(input int n);
    int r;
    int pixel;
    int sel;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r == 0) begin
        for (int b = 0; b < stim_bins; b++)
          send_item(REQ_READ, $urandom_range(255), b);
      end else if (r < 70) begin
        case ($urandom_range(2))
          0: pixel = $urandom_range(255);
          1: pixel = $urandom_range(stim_maxv);
          default: begin
            pixel = stim_maxv + $urandom_range(3);
            if (pixel > 255) pixel = 255;
          end
        endcase
        send_item(REQ_ACCUM, pixel, $urandom_range(63));
      end else begin
        if ($urandom_range(9) < 8) sel = $urandom_range(stim_bins - 1);
        else sel = $urandom_range(63);
        send_item(REQ_READ, $urandom_range(255), sel);
      end
    end
  endtask

  initial begin
    int nb;
    int mv;
    logic [DATA_W-1:0] recip;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unit reciprocal, default bins of width four
    cfg_write(REG_RECIP, DATA_W'(1 << 24));
    send_item(REQ_ACCUM, 0, 0);
    send_item(REQ_ACCUM, 0, 63);
    send_item(REQ_ACCUM, 3, 0);
    send_item(REQ_ACCUM, 4, 0);
    send_item(REQ_ACCUM, 255, 0);
    send_item(REQ_ACCUM, 252, 0);
    send_item(REQ_ACCUM, 251, 0);
    send_item(REQ_READ, 0, 0);      // saturated fraction
    send_item(REQ_READ, 0, 1);      // fraction exactly one
    send_item(REQ_READ, 255, 63);
    send_item(REQ_READ, 0, 62);
    send_item(REQ_READ, 0, 0);      // bin just cleared
    send_item(REQ_READ, 0, 40);     // bin never hit
    send_item(REQ_ACCUM, 255, 63);
    send_item(REQ_ACCUM, 128, 21);
    send_item(REQ_READ, 255, 63);
    send_item(REQ_READ, 170, 32);
    send_item(REQ_READ, 85, 42);
    wait_quiet();

    // random phases over register settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin nb = 64; mv = 255; recip = '0; end
        1: begin nb = 1; mv = 255; recip = 32'h01FF_FFFF; end
        2: begin nb = 0; mv = 0; recip = $urandom & 32'h01FF_FFFF; end
        3: begin nb = 127; mv = 100; recip = 32'h0100_0000; end
        4: begin nb = 10; mv = 37; recip = $urandom_range(1 << 20); end
        5: begin nb = 65; mv = 1; recip = $urandom & 32'h01FF_FFFF; end
        6: begin
          nb = $urandom_range(64, 1);
          mv = $urandom_range(255, 1);
          recip = $urandom_range(1 << 24, 1 << 16);
        end
        default: begin
          nb = $urandom_range(63, 2);
          mv = 255;
          recip = $urandom_range(1 << 24);
        end
      endcase
      apply_setting(nb, mv, recip);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 74; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 74; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      run_random(PHASE_ITEMS);
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("intensity_histogram_unit_test: PASS");
    end else begin
      $display("intensity_histogram_unit_test: FAIL");
    end
    $finish;
  end

endmodule
